[rtl/bbe_pkg.sv]
// bbe_pkg: shared types, register indexes and constants of the bouncing ball envelope
// used by every module of the block; depends on nothing else
package bbe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_START_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic [11:0] START_KNOB_RESET  = 12'd1024;
    localparam logic [13:0] GRAVITY_RESET     = 14'd10033;
    localparam logic [10:0] RESTITUTION_RESET = 11'd707;
    localparam logic [19:0] PERIOD_RESET      = 20'd89478;

    localparam logic signed [31:0] START_HEIGHT_RESET = 32'sd167772;
    localparam logic signed [31:0] APEX_LIMIT         = 32'sd1678;
    localparam logic signed [15:0] TRIG_HIGH_LEVEL    = 16'sd1024;
    localparam logic [13:0]        FULL_SCALE         = 14'd10240;

    localparam int DIV_Q_W = 15;
    localparam int DIV_N_W = 46;

    localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TRIG,
        OP_STOP,
        OP_MUL_G,
        OP_VEL_G,
        OP_MUL_V,
        OP_HEIGHT,
        OP_MUL_R,
        OP_VEL_R,
        OP_DIV_H,
        OP_DIV_A
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIG,
        S_CHECK,
        S_MUL_G,
        S_VEL_G,
        S_MUL_V,
        S_HEIGHT,
        S_MUL_R,
        S_VEL_R,
        S_DIV_H,
        S_WAIT_H,
        S_DIV_A,
        S_WAIT_A,
        S_OUT
    } state_t;

    typedef struct packed {
        logic take;
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic running;
        logic falling;
        logic stop_hit;
        logic rise_go;
        logic ground_hit;
        logic div_done;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = $signed(x[31:0]);
        end
        return r;
    endfunction

endpackage

[rtl/bouncing_ball_envelope.sv]
// bouncing_ball_envelope: top level of the bouncing ball envelope generator
// uses bbe_pkg, bbe_ctrl and bbe_datapath
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  input     in_valid / in_ready    trig_voltage run_button height_cv gravity_cv
//                                   restitution_cv
//  output    out_valid / out_ready  gate pitch pitch_step
//  config    cfg_write              cfg_index cfg_data
//
// while the ball moves a sample runs trigger, check, gravity step, distance step and both
// ratios, each on the serial divider; a bounce adds the restitution step, an apex skips
// the distance step, and with no run active or a stopped run it goes from check to output
// one sample at a time: the next input is taken once the result is in the output register
// rst_n clears the state asynchronously and restores the configuration defaults
// a stalled output only holds the sequencer in its last step
module bouncing_ball_envelope
    import bbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [14:0]    trig_voltage,
    input  logic                  run_button,
    input  logic signed [14:0]    height_cv,
    input  logic signed [14:0]    gravity_cv,
    input  logic signed [14:0]    restitution_cv,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  gate,
    output logic [13:0]           pitch,
    output logic [13:0]           pitch_step,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    bbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bbe_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .trig_voltage   (trig_voltage),
        .run_button     (run_button),
        .height_cv      (height_cv),
        .gravity_cv     (gravity_cv),
        .restitution_cv (restitution_cv),
        .gate           (gate),
        .pitch          (pitch),
        .pitch_step     (pitch_step)
    );

endmodule

[rtl/bbe_div.sv]
// bbe_div: restoring divider, one quotient bit per cycle
// uses bbe_pkg for the quotient and dividend widths
module bbe_div
    import bbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [30:0]        divisor,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);

    logic [DIV_N_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] den_reg;
    logic [DIV_Q_W-1:0] q_reg;
    logic [3:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign fits = rem_reg >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(DIV_Q_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
        end
    end

    // divisor starts aligned to the top quotient bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            den_reg <= {1'b0, divisor, {(DIV_Q_W-1){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/bbe_datapath.sv]
// bbe_datapath: configuration, ball state, shared multiplier and ratio logic
// uses bbe_pkg and instantiates bbe_div; driven by bbe_ctrl commands
module bbe_datapath
    import bbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic signed [14:0]    trig_voltage,
    input  logic                  run_button,
    input  logic signed [14:0]    height_cv,
    input  logic signed [14:0]    gravity_cv,
    input  logic signed [14:0]    restitution_cv,
    output logic                  gate,
    output logic [13:0]           pitch,
    output logic [13:0]           pitch_step
);

    logic [11:0] start_knob_reg;
    logic [13:0] gravity_knob_reg;
    logic [10:0] restit_knob_reg;
    logic [19:0] period_reg;

    logic               trig_high_reg;
    logic               running_reg;
    logic               falling_reg;
    logic signed [31:0] height_reg;
    logic signed [31:0] start_reg;
    logic signed [31:0] lowest_reg;
    logic signed [31:0] vel_reg;

    logic signed [15:0] level_reg;
    logic signed [14:0] hcv_reg;
    logic signed [14:0] gcv_reg;
    logic signed [14:0] rcv_reg;
    logic signed [52:0] prod_reg;
    logic [13:0]        ratio_h_reg;
    logic [13:0]        ratio_a_reg;
    logic               div_sel_reg;
    logic               div_zero_reg;
    logic               div_clamp_reg;
    logic               gate_reg;
    logic [13:0]        pitch_reg;
    logic [13:0]        step_reg;

    logic signed [15:0] level_in;
    logic signed [16:0] h_sum;
    logic signed [16:0] g_sum;
    logic signed [16:0] r_sum;
    logic signed [31:0] h_load;
    logic signed [31:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [52:0] mul_p;
    logic signed [52:0] dv_full;
    logic signed [52:0] dh_full;
    logic signed [52:0] vr_full;
    logic signed [39:0] vel40;
    logic signed [39:0] h40;
    logic signed [39:0] dv40;
    logic signed [39:0] dh40;
    logic signed [31:0] vel_fall;
    logic signed [31:0] vel_rise;
    logic signed [31:0] h_fall;
    logic signed [31:0] h_rise;
    logic signed [31:0] v_bounce;

    logic                 div_start;
    logic signed [31:0]   div_num;
    logic [DIV_N_W-1:0]   num_ext;
    logic [DIV_N_W-1:0]   dividend;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   quotient;
    logic [13:0]          ratio_q;

    assign level_in = 16'(trig_voltage) + (run_button ? TRIG_HIGH_LEVEL : 16'sd0);
    assign h_sum    = $signed({5'b0, start_knob_reg}) + 17'(hcv_reg);
    assign g_sum    = $signed({3'b0, gravity_knob_reg}) + 17'(gcv_reg);
    assign r_sum    = $signed({6'b0, restit_knob_reg}) + 17'(rcv_reg);
    assign h_load   = $signed({h_sum[16], h_sum, 14'b0});

    // one shared multiplier for gravity step, distance step and bounce
    assign mul_a = (cmd.op == OP_MUL_G) ? 32'(g_sum) : vel_reg;
    assign mul_b = (cmd.op == OP_MUL_R) ? 21'(r_sum) : $signed({1'b0, period_reg});
    assign mul_p = mul_a * mul_b;

    // arithmetic shifts round toward minus infinity
    assign dv_full = prod_reg >>> 18;
    assign dh_full = prod_reg >>> 32;
    assign vr_full = prod_reg >>> 10;

    assign vel40 = 40'(vel_reg);
    assign h40   = 40'(height_reg);
    assign dv40  = $signed(dv_full[39:0]);
    assign dh40  = $signed(dh_full[39:0]);

    assign vel_fall = sat32(vel40 + dv40);
    assign vel_rise = sat32(vel40 - dv40);
    assign h_fall   = sat32(h40 - dh40);
    assign h_rise   = sat32(h40 + dh40);
    assign v_bounce = sat32($signed(vr_full[39:0]));

    // numerator times full scale as two shifted adds
    assign div_start = (cmd.op == OP_DIV_H) || (cmd.op == OP_DIV_A);
    assign div_num   = (cmd.op == OP_DIV_A) ? lowest_reg : height_reg;
    assign num_ext   = {15'b0, div_num[30:0]};
    assign dividend  = (num_ext << 13) + (num_ext << 11);
    assign ratio_q   = (quotient > {1'b0, FULL_SCALE}) ? FULL_SCALE : quotient[13:0];

    bbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (start_reg[30:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        stat            = '0;
        stat.running    = running_reg;
        stat.falling    = falling_reg;
        stat.stop_hit   = running_reg && (lowest_reg < APEX_LIMIT);
        stat.rise_go    = vel_rise > 32'sd0;
        stat.ground_hit = h_fall <= 32'sd0;
        stat.div_done   = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_knob_reg   <= START_KNOB_RESET;
            gravity_knob_reg <= GRAVITY_RESET;
            restit_knob_reg  <= RESTITUTION_RESET;
            period_reg       <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_HEIGHT:  start_knob_reg   <= cfg_data[11:0];
                REG_GRAVITY:       gravity_knob_reg <= cfg_data[13:0];
                REG_RESTITUTION:   restit_knob_reg  <= cfg_data[10:0];
                REG_SAMPLE_PERIOD: period_reg       <= cfg_data[19:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_high_reg <= 1'b0;
            running_reg   <= 1'b0;
            falling_reg   <= 1'b0;
            height_reg    <= '0;
            start_reg     <= START_HEIGHT_RESET;
            lowest_reg    <= '0;
            vel_reg       <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_TRIG:
                begin
                    if (trig_high_reg)
                    begin
                        if (level_reg <= 16'sd0)
                        begin
                            trig_high_reg <= 1'b0;
                        end
                    end
                    else if (level_reg >= TRIG_HIGH_LEVEL)
                    begin
                        trig_high_reg <= 1'b1;
                        running_reg   <= 1'b1;
                        falling_reg   <= 1'b1;
                        height_reg    <= h_load;
                        start_reg     <= h_load;
                        lowest_reg    <= h_load;
                        vel_reg       <= '0;
                    end
                end
                OP_STOP:
                begin
                    running_reg <= 1'b0;
                    height_reg  <= '0;
                    lowest_reg  <= '0;
                end
                OP_VEL_G:
                begin
                    if (falling_reg)
                    begin
                        vel_reg <= vel_fall;
                    end
                    else if (vel_rise > 32'sd0)
                    begin
                        vel_reg <= vel_rise;
                    end
                    else
                    begin
                        // apex reached
                        vel_reg     <= '0;
                        falling_reg <= 1'b1;
                        if (height_reg < lowest_reg)
                        begin
                            lowest_reg <= height_reg;
                        end
                    end
                end
                OP_HEIGHT:
                begin
                    if (falling_reg)
                    begin
                        if (h_fall <= 32'sd0)
                        begin
                            height_reg  <= '0;
                            falling_reg <= 1'b0;
                        end
                        else
                        begin
                            height_reg <= h_fall;
                        end
                    end
                    else
                    begin
                        height_reg <= h_rise;
                    end
                end
                OP_VEL_R:
                begin
                    vel_reg <= v_bounce;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            level_reg <= level_in;
            hcv_reg   <= height_cv;
            gcv_reg   <= gravity_cv;
            rcv_reg   <= restitution_cv;
        end
        if ((cmd.op == OP_MUL_G) || (cmd.op == OP_MUL_V) || (cmd.op == OP_MUL_R))
        begin
            prod_reg <= mul_p;
        end
        if (div_start)
        begin
            div_sel_reg   <= (cmd.op == OP_DIV_A);
            div_zero_reg  <= (div_num <= 32'sd0) || (start_reg <= 32'sd0);
            div_clamp_reg <= {1'b0, div_num[30:0]} >= {start_reg[30:0], 1'b0};
        end
        if (div_done)
        begin
            if (div_sel_reg)
            begin
                ratio_a_reg <= div_zero_reg ? 14'd0 : (div_clamp_reg ? FULL_SCALE : ratio_q);
            end
            else
            begin
                ratio_h_reg <= div_zero_reg ? 14'd0 : (div_clamp_reg ? FULL_SCALE : ratio_q);
            end
        end
        if (cmd.out_load)
        begin
            gate_reg  <= running_reg && falling_reg;
            pitch_reg <= running_reg ? ratio_h_reg : 14'd0;
            step_reg  <= running_reg ? ratio_a_reg : 14'd0;
        end
    end

    assign gate       = gate_reg;
    assign pitch      = pitch_reg;
    assign pitch_step = step_reg;

endmodule

[rtl/bbe_ctrl.sv]
// bbe_ctrl: sequencer for one sample step and the output handshake
// uses bbe_pkg for state, command and status types
module bbe_ctrl
    import bbe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    assign load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_TRIG;
                end
            end
            S_TRIG:   state_next = S_CHECK;
            S_CHECK:
            begin
                if (!stat.running || stat.stop_hit)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL_G;
                end
            end
            S_MUL_G:  state_next = S_VEL_G;
            S_VEL_G:
            begin
                if (stat.falling || stat.rise_go)
                begin
                    state_next = S_MUL_V;
                end
                else
                begin
                    state_next = S_DIV_H;
                end
            end
            S_MUL_V:  state_next = S_HEIGHT;
            S_HEIGHT:
            begin
                if (stat.falling && stat.ground_hit)
                begin
                    state_next = S_MUL_R;
                end
                else
                begin
                    state_next = S_DIV_H;
                end
            end
            S_MUL_R:  state_next = S_VEL_R;
            S_VEL_R:  state_next = S_DIV_H;
            S_DIV_H:  state_next = S_WAIT_H;
            S_WAIT_H:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:  state_next = S_WAIT_A;
            S_WAIT_A:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.take     = (state_reg == S_IDLE) && in_valid;
        cmd.out_load = load;
        case (state_reg)
            S_TRIG:   cmd.op = OP_TRIG;
            S_CHECK:  cmd.op = stat.stop_hit ? OP_STOP : OP_NONE;
            S_MUL_G:  cmd.op = OP_MUL_G;
            S_VEL_G:  cmd.op = OP_VEL_G;
            S_MUL_V:  cmd.op = OP_MUL_V;
            S_HEIGHT: cmd.op = OP_HEIGHT;
            S_MUL_R:  cmd.op = OP_MUL_R;
            S_VEL_R:  cmd.op = OP_VEL_R;
            S_DIV_H:  cmd.op = OP_DIV_H;
            S_DIV_A:  cmd.op = OP_DIV_A;
            default:  cmd.op = OP_NONE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/bbe_checker.sv]
// bbe_checker: port-level checks of the bouncing ball envelope, bound to the top level
// uses bbe_pkg for the full scale constant
module bbe_checker
    import bbe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [13:0]           pitch,
    input logic [13:0]           pitch_step
);

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output dropped while stalled");

    // one sample in flight: no new transfer right after one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    // a result never appears the cycle after its input transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

    // both levels stay within ten volts
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch <= FULL_SCALE) && (pitch_step <= FULL_SCALE))
        else $error("output above full scale");

endmodule

bind bouncing_ball_envelope bbe_checker u_bbe_checker (.*);
